/* rtl/b64_pkg.sv */
// Shared types, codes and character-mapping functions for the Base64 codec.
`default_nettype none

package b64_pkg;

  // Codec mode codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Padding character
  localparam logic [7:0] PAD_CHAR = 8'h3d;

  // Character and value markers
  localparam logic [7:0] BAD_VALUE = 8'hff;

  // Input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } src_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;
  } dst_item_t;

  // Results of one completed group, entry 0 goes out first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            last;
    logic            err;
  } grp_t;

  // Map a 6-bit value to its alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    case (v) inside
      [6'd0:6'd25]:  enc_char = 8'(w + 8'd65);
      [6'd26:6'd51]: enc_char = 8'(w + 8'd71);
      [6'd52:6'd61]: enc_char = 8'(w - 8'd4);
      6'd62:         enc_char = 8'h2b;
      default:       enc_char = 8'h2f;
    endcase
  endfunction

  // Map a character to its 6-bit value, anything else gives 0xff
  function automatic logic [7:0] dec_val(input logic [7:0] c);
    case (c) inside
      [8'h41:8'h5a]: dec_val = 8'(c - 8'd65);
      [8'h61:8'h7a]: dec_val = 8'(c - 8'd71);
      [8'h30:8'h39]: dec_val = 8'(c + 8'd4);
      8'h2b:         dec_val = 8'h3e;
      8'h2f:         dec_val = 8'h3f;
      default:       dec_val = BAD_VALUE;
    endcase
  endfunction

endpackage

`default_nettype wire

/* rtl/b64_group.sv */
// Group assembly and one-pass encode/decode of a completed group.
`default_nettype none

module b64_group (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              mode_we,
  input  wire logic              mode_wdata,
  input  wire logic              take,
  input  wire b64_pkg::src_item_t item,
  output logic                   produce,
  output b64_pkg::grp_t          grp
);

  logic            mode;
  logic [1:0]      phase;
  logic [1:0]      phase_next;
  logic [2:0][7:0] held;

  logic [7:0] d;
  logic [7:0] b0, b1, b2;
  logic [7:0] v0, v1, v2, v3;
  logic [7:0] o0, o1, o2;

  assign d = item.data_byte;

  // Decide whether this item closes a group
  always_comb begin
    if (mode == b64_pkg::MODE_DECODE) begin
      produce = item.is_last || (phase == 2'd3);
    end else begin
      produce = item.is_last || (phase == 2'd2);
    end
    phase_next = produce ? 2'd0 : 2'(phase + 2'd1);
  end

  // Hold mode, group phase and held items
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= b64_pkg::MODE_ENCODE;
      phase <= 2'd0;
    end else if (mode_we) begin
      mode  <= mode_wdata;
      phase <= 2'd0;
    end else if (take) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (phase != 2'd3)) begin
      held[phase] <= d;
    end
  end

  // Encode operands: missing bytes of a short group read as zero
  always_comb begin
    b0 = (phase == 2'd0) ? d : held[0];
    case (phase)
      2'd1:    b1 = d;
      2'd2:    b1 = held[1];
      default: b1 = 8'd0;
    endcase
    b2 = (phase == 2'd2) ? d : 8'd0;
  end

  // Decode operands and output bytes
  always_comb begin
    v0 = b64_pkg::dec_val(held[0]);
    v1 = b64_pkg::dec_val(held[1]);
    v2 = b64_pkg::dec_val(held[2]);
    v3 = b64_pkg::dec_val(d);
    o0 = 8'(v0 << 2) | (v1 >> 4);
    o1 = (8'(v1 << 4) & 8'hf0) | (v2 >> 2);
    o2 = (8'(v2 << 6) & 8'hc0) | v3;
  end

  // Build the group result
  always_comb begin
    grp = '0;
    if (mode == b64_pkg::MODE_DECODE) begin
      if (phase != 2'd3) begin
        // short final quad: one error result
        grp.cnt  = 3'd1;
        grp.last = 1'b1;
        grp.err  = 1'b1;
      end else begin
        grp.bytes[0] = o0;
        grp.bytes[1] = o1;
        grp.bytes[2] = o2;
        grp.last     = item.is_last;
        grp.cnt      = 3'd3;
        if (item.is_last && (d == b64_pkg::PAD_CHAR)) begin
          if (held[2] != b64_pkg::PAD_CHAR) begin
            grp.cnt = 3'd2;
          end else if (held[1] != b64_pkg::PAD_CHAR) begin
            grp.cnt = 3'd1;
          end
        end
      end
    end else begin
      grp.bytes[0] = b64_pkg::enc_char(b0[7:2]);
      grp.bytes[1] = b64_pkg::enc_char({b0[1:0], b1[7:4]});
      grp.bytes[2] = (phase != 2'd0) ? b64_pkg::enc_char({b1[3:0], b2[7:6]})
                                     : b64_pkg::PAD_CHAR;
      grp.bytes[3] = (phase == 2'd2) ? b64_pkg::enc_char(b2[5:0])
                                     : b64_pkg::PAD_CHAR;
      grp.cnt      = 3'd4;
      grp.last     = item.is_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/base64_codec_top.sv */
// Top level of the streaming Base64 codec: group logic, result buffer, output register.
// A closing item loads its group's results into the buffer; each then passes the output register.
// Throughput: one result per cycle on the output while dst_stall is low; a group's results
//   leave its buffer one per cycle while the output register is free to take them.
// Items that close no group are taken every cycle; a closing item waits for the buffer.
// Reset (rst, synchronous): mode goes to encode, group phase, buffer and output clear.
`default_nettype none

module base64_codec_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               mode_we,
  input  wire logic               mode_wdata,
  input  wire logic               src_valid,
  output logic                    src_stall,
  input  wire b64_pkg::src_item_t src_item,
  output logic                    dst_valid,
  input  wire logic               dst_stall,
  output b64_pkg::dst_item_t      dst_item
);

  logic            produce;
  b64_pkg::grp_t   grp;
  logic            take;
  logic            load;
  logic            mv;
  logic            buf_free;
  logic [3:0][7:0] buf_bytes;
  logic [2:0]      rem;
  logic            buf_last;
  logic            buf_err;

  b64_group u_group (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .take       (take),
    .item       (src_item),
    .produce    (produce),
    .grp        (grp)
  );

  // Move one result when the output register is empty or being taken
  assign mv        = (rem != 3'd0) && (!dst_valid || !dst_stall);
  assign buf_free  = (rem == 3'd0) || (mv && (rem == 3'd1));
  assign src_stall = produce && !buf_free;
  assign take      = src_valid && !src_stall;
  assign load      = take && produce;

  // Load a finished group, else advance by one entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
    end else if (load) begin
      rem <= grp.cnt;
    end else if (mv) begin
      rem <= 3'(rem - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_bytes <= grp.bytes;
      buf_last  <= grp.last;
      buf_err   <= grp.err;
    end else if (mv) begin
      buf_bytes <= {8'd0, buf_bytes[3:1]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (mv) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv) begin
      dst_item.out_byte  <= buf_bytes[0];
      dst_item.out_last  <= buf_last && (rem == 3'd1);
      dst_item.out_error <= buf_err;
    end
  end

endmodule

`default_nettype wire

/* rtl/b64_checker.sv */
// Port-level checks for the Base64 codec top level and their bind.
`default_nettype none

module b64_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               src_valid,
  input wire logic               src_stall,
  input wire b64_pkg::src_item_t src_item,
  input wire logic               dst_valid,
  input wire logic               dst_stall,
  input wire b64_pkg::dst_item_t dst_item
);

  // Hold a stalled result
  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_item))
    else $error("stalled result item changed");

  // Hold a stalled input item
  a_src_hold: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_stall |=> src_valid && $stable(src_item))
    else $error("stalled input item changed");

  // An error item is a lone zero item that closes the message
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_item.out_error |-> dst_item.out_last && (dst_item.out_byte == 8'd0))
    else $error("error item malformed");

  // Output register empties on reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("result valid after reset");

  // Input stalls only behind a result that is pending or shows next cycle
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    src_stall |=> dst_valid)
    else $error("input stalled with no pending result");

endmodule

bind base64_codec_top b64_checker u_b64_checker (
  .clk        (clk),
  .rst        (rst),
  .src_valid  (src_valid),
  .src_stall  (src_stall),
  .src_item   (src_item),
  .dst_valid  (dst_valid),
  .dst_stall  (dst_stall),
  .dst_item   (dst_item)
);

`default_nettype wire

/* dv/base64_codec_top_tb.sv */
// Self-checking testbench for the Base64 codec: directed and random messages in both modes.
`default_nettype none

module base64_codec_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAUSE_CYCLES = 8;
  localparam int STUCK_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 100;
  localparam int PHASE_ITEMS  = 22;
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               mode_we    = 1'b0;
  logic               mode_wdata = b64_pkg::MODE_ENCODE;
  logic               src_valid  = 1'b0;
  logic               src_stall;
  b64_pkg::src_item_t src_item   = '0;
  logic               dst_valid;
  logic               dst_stall  = 1'b0;
  b64_pkg::dst_item_t dst_item;

  // Items waiting to be driven, and results the codec still owes
  b64_pkg::src_item_t pending_src[$];
  b64_pkg::dst_item_t awaited_out[$];

  // Predictor state
  logic       model_mode  = b64_pkg::MODE_ENCODE;
  int         model_phase = 0;
  logic [7:0] model_held[3];

  bit src_fired    = 1'b0;
  bit calm         = 1'b0;
  int idle_odds    = 0;
  int src_gap      = 0;
  int stall_left   = 0;
  int mismatches   = 0;
  int stuck_cycles = 0;

  base64_codec_top uut (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_item   (src_item),
    .dst_valid  (dst_valid),
    .dst_stall  (dst_stall),
    .dst_item   (dst_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Alphabet character for a 6-bit value
  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    return ALPHABET[8*(63 - int'(v)) +: 8];
  endfunction

  // 6-bit value of a character, BAD_VALUE outside the alphabet
  function automatic logic [7:0] sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 8'd26;
    if (c >= "0" && c <= "9") return c - "0" + 8'd52;
    if (c == "+") return 8'h3e;
    if (c == "/") return 8'h3f;
    return b64_pkg::BAD_VALUE;
  endfunction

  function automatic void await_out(input logic [7:0] b, input logic last, input logic err);
    awaited_out.push_back({b, last, err});
  endfunction

  // Advance the predictor by one accepted item and queue the results it causes
  function automatic void model_codec_item(input b64_pkg::src_item_t it);
    int         n;
    int         pad;
    logic [7:0] b0, b1, b2, d0, d1, d2, d3, o0, o1, o2;
    n   = model_phase;
    pad = 0;
    if (model_mode == b64_pkg::MODE_ENCODE) begin
      model_held[n] = it.data_byte;
      n++;
      if (n < 3 && !it.is_last) begin
        model_phase = n;
      end else begin
        model_phase = 0;
        b0 = model_held[0];
        b1 = (n >= 2) ? model_held[1] : 8'h00;
        b2 = (n >= 3) ? model_held[2] : 8'h00;
        await_out(b64_symbol(b0[7:2]), 1'b0, 1'b0);
        await_out(b64_symbol({b0[1:0], b1[7:4]}), 1'b0, 1'b0);
        await_out((n >= 2) ? b64_symbol({b1[3:0], b2[7:6]}) : b64_pkg::PAD_CHAR,
                  1'b0, 1'b0);
        await_out((n >= 3) ? b64_symbol(b2[5:0]) : b64_pkg::PAD_CHAR, it.is_last, 1'b0);
      end
    end else if (n < 3) begin
      // Hold a partial quad; a marked last char here is a length error
      model_held[n] = it.data_byte;
      if (it.is_last) begin
        model_phase = 0;
        await_out(8'h00, 1'b1, 1'b1);
      end else begin
        model_phase = n + 1;
      end
    end else begin
      model_phase = 0;
      d0 = sextet_of(model_held[0]);
      d1 = sextet_of(model_held[1]);
      d2 = sextet_of(model_held[2]);
      d3 = sextet_of(it.data_byte);
      o0 = {d0[5:0], 2'b00} | {4'h0, d1[7:4]};
      o1 = {d1[3:0], 4'h0} | {2'b00, d2[7:2]};
      o2 = {d2[1:0], 6'h00} | d3;
      // Padding counts only on the final quad, and only for one or two '='
      if (it.is_last && it.data_byte == b64_pkg::PAD_CHAR) begin
        if (model_held[2] != b64_pkg::PAD_CHAR) pad = 1;
        else if (model_held[1] != b64_pkg::PAD_CHAR) pad = 2;
      end
      await_out(o0, pad == 2, 1'b0);
      if (pad != 2) await_out(o1, pad == 1, 1'b0);
      if (pad == 0) await_out(o2, it.is_last, 1'b0);
    end
  endfunction

  function automatic void queue_item(input logic [7:0] b, input logic last);
    pending_src.push_back({b, last});
  endfunction

  function automatic void queue_text(input string s, input bit mark_last);
    for (int i = 0; i < s.len(); i++) queue_item(s[i], mark_last && i == s.len() - 1);
  endfunction

  // Random raw bytes, usually closed by a marked last byte
  function automatic int queue_encode_message();
    int len;
    bit marked;
    len    = $urandom_range(1, 10);
    marked = $urandom_range(0, 7) != 0;
    for (int i = 0; i < len; i++) queue_item(8'($urandom_range(0, 255)), marked && i == len - 1);
    return len;
  endfunction

  // Whole quads with random content and zero to four trailing '=' characters
  function automatic int queue_decode_message();
    int         len;
    int         pads;
    logic [7:0] c;
    len  = 4 * $urandom_range(1, 3);
    pads = $urandom_range(0, 9);
    if (pads < 5) pads = 0;
    else if (pads < 7) pads = 1;
    else if (pads < 9) pads = 2;
    else pads = $urandom_range(3, 4);
    for (int i = 0; i < len; i++) begin
      c = (i >= len - pads) ? b64_pkg::PAD_CHAR : b64_symbol(6'($urandom_range(0, 63)));
      queue_item(c, i == len - 1);
    end
    return len;
  endfunction

  // Broken messages: odd lengths, stray bytes, sometimes no last mark
  function automatic int queue_noise_message();
    int         len;
    bit         marked;
    logic [7:0] c;
    len    = $urandom_range(1, 7);
    marked = $urandom_range(0, 3) != 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 1) != 0) c = 8'($urandom_range(0, 255));
      else if ($urandom_range(0, 4) == 0) c = b64_pkg::PAD_CHAR;
      else c = b64_symbol(6'($urandom_range(0, 63)));
      queue_item(c, marked && i == len - 1);
    end
    return len;
  endfunction

  // Write the mode register while the codec is idle; a write drops any partial group
  task automatic set_codec_mode(input logic m);
    @(negedge clk);
    mode_we    <= 1'b1;
    mode_wdata <= m;
    @(negedge clk);
    mode_we     <= 1'b0;
    model_mode  = m;
    model_phase = 0;
  endtask

  // Wait until every item is taken and every result is in, then let the pipe settle
  task automatic settle_codec();
    while (pending_src.size() != 0 || src_valid || awaited_out.size() != 0) @(negedge clk);
    repeat (PAUSE_CYCLES) @(negedge clk);
  endtask

  // Drive items from the pending queue, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else if (src_valid && !src_fired) begin
      // hold the stalled item
    end else if (!calm && src_gap > 0) begin
      src_valid <= 1'b0;
      src_gap--;
    end else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      src_valid <= 1'b0;
      src_gap = $urandom_range(0, 8);
    end else if (pending_src.size() != 0) begin
      src_valid <= 1'b1;
      src_item  <= pending_src.pop_front();
    end else begin
      src_valid <= 1'b0;
    end
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (rst || calm) begin
      dst_stall <= 1'b0;
    end else if (stall_left > 0) begin
      dst_stall <= 1'b1;
      stall_left--;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      dst_stall <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      dst_stall <= 1'b0;
    end
  end

  // Predict on accepted items, check accepted results against the oldest prediction
  always @(posedge clk) begin : check_side
    b64_pkg::dst_item_t want;
    src_fired = !rst && src_valid && !src_stall;
    if (src_fired) model_codec_item(src_item);
    if (!rst && dst_valid && !dst_stall) begin
      if (awaited_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected item byte=%02h last=%0b error=%0b", $realtime,
                   dst_item.out_byte, dst_item.out_last, dst_item.out_error);
      end else begin
        want = awaited_out.pop_front();
        if (dst_item.out_byte !== want.out_byte || dst_item.out_last !== want.out_last ||
            dst_item.out_error !== want.out_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch byte %02h/%02h last %0b/%0b error %0b/%0b (exp/act)",
                     $realtime, want.out_byte, dst_item.out_byte, want.out_last,
                     dst_item.out_last, want.out_error, dst_item.out_error);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    do begin
      @(posedge clk);
      if ((src_valid && !src_stall) || (dst_valid && !dst_stall)) stuck_cycles = 0;
      else stuck_cycles++;
    end while (stuck_cycles < STUCK_LIMIT);
    $display("base64_codec_top_tb failed");
    $finish;
  end

  initial begin : stimulus
    int   random_count;
    int   phase_count;
    logic phase_mode;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    idle_odds = 4;

    // Encode: one byte pads twice, two bytes pad once, full group hits '+' and '/'
    set_codec_mode(b64_pkg::MODE_ENCODE);
    queue_item(8'h00, 1'b1);
    queue_item(8'hff, 1'b0);
    queue_item(8'hff, 1'b1);
    queue_item(8'hfb, 1'b0);
    queue_item(8'hef, 1'b0);
    queue_item(8'hbf, 1'b1);
    // Leave a partial group behind for the mode write to drop
    queue_item(8'h5a, 1'b0);
    settle_codec();

    // Decode: full quad then two pads, one pad, three pads, short message error
    set_codec_mode(b64_pkg::MODE_DECODE);
    queue_text("TWFuTQ==", 1'b1);
    queue_text("TWE=", 1'b1);
    queue_text("A===", 1'b1);
    queue_text("Q", 1'b1);
    settle_codec();

    // Random phases, alternating mode; the last phase runs without idling
    random_count = 0;
    phase_mode   = b64_pkg::MODE_DECODE;
    while (!calm) begin
      phase_mode = (phase_mode == b64_pkg::MODE_ENCODE) ? b64_pkg::MODE_DECODE
                                                        : b64_pkg::MODE_ENCODE;
      case ($urandom_range(0, 2))
        0:       idle_odds = 0;
        1:       idle_odds = 3;
        default: idle_odds = 8;
      endcase
      calm = random_count + PHASE_ITEMS >= RANDOM_ITEMS;
      set_codec_mode(phase_mode);
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) phase_count += queue_noise_message();
        else if (phase_mode == b64_pkg::MODE_DECODE) phase_count += queue_decode_message();
        else phase_count += queue_encode_message();
      end
      random_count += phase_count;
      settle_codec();
    end

    if (mismatches == 0 && awaited_out.size() == 0) begin
      $display("base64_codec_top_tb passed");
    end else begin
      $display("base64_codec_top_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* base64_codec_top.f */
rtl/b64_pkg.sv
rtl/b64_group.sv
rtl/base64_codec_top.sv
rtl/b64_checker.sv
dv/base64_codec_top_tb.sv
